>>> rtl/core/irlc_pkg.sv
package irlc_pkg;

	// What the strip shows
	typedef enum logic [1:0] {
		SRC_BLACK   = 2'd0,
		SRC_SOLID   = 2'd1,
		SRC_RAINBOW = 2'd2
	} src_t;

	typedef enum logic {
		MODE_RAINBOW = 1'b0,
		MODE_SOLID   = 1'b1
	} mode_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_CODE = 1'b1
	} op_t;

	// Remote codes with a fixed action
	localparam logic [31:0] CODE_POWER_OFF  = 32'h00FF_609F;
	localparam logic [31:0] CODE_BRIGHT_UP  = 32'h00FF_A05F;
	localparam logic [31:0] CODE_BRIGHT_DN  = 32'h00FF_20DF;
	localparam logic [31:0] CODE_RAINBOW    = 32'h00FF_C837;
	localparam logic [31:0] CODE_FASTER_A   = 32'h00FF_F00F;
	localparam logic [31:0] CODE_FASTER_B   = 32'h35A9_425F;
	localparam logic [31:0] CODE_SLOWER_A   = 32'h00FF_C827;
	localparam logic [31:0] CODE_SLOWER_B   = 32'h86B0_E697;

	// Solid color palette: two codes select each entry
	localparam int PalDepth = 16;

	localparam logic [31:0] PAL_CODE_A [PalDepth] = '{
		32'h00FF_50AF, 32'h00FF_10EF, 32'h00FF_708F, 32'h00FF_906F,
		32'h00FF_B04F, 32'h00FF_D02F, 32'h00FF_9867, 32'h00FF_18E7,
		32'h00FF_30CF, 32'h00FF_A857, 32'h00FF_6897, 32'h00FF_8877,
		32'h00FF_08F7, 32'h00FF_48B7, 32'h00FF_58A7, 32'h00FF_28D7
	};

	localparam logic [31:0] PAL_CODE_B [PalDepth] = '{
		32'h2A89_195F, 32'h8C22_657B, 32'h44C4_07DB, 32'hE5CF_BD7F,
		32'hF0C4_1643, 32'hD538_681B, 32'h9748_3BFB, 32'h3D9A_E3F7,
		32'h9716_BE3F, 32'hA3C8_EDDB, 32'hC101_E57B, 32'h9EF4_941F,
		32'h4547_3C1B, 32'hF377_C5B7, 32'hDC01_97DB, 32'h1354_9BDF
	};

	localparam logic [23:0] PAL_RGB [PalDepth] = '{
		24'h0000FF, 24'h00FF00, 24'hFF55FF, 24'hFF0000,
		24'hFF4500, 24'hFFFFFF, 24'h999900, 24'hADD8E6,
		24'h90EE90, 24'hFFA500, 24'hFF00FF, 24'hFFFF55,
		24'h5555FF, 24'hEE82EE, 24'hEE82EE, 24'h008080
	};

	localparam logic [7:0]  BRIGHT_RESET      = 8'd255;
	localparam logic [7:0]  BRIGHT_STEP       = 8'd10;
	localparam logic [7:0]  BRIGHT_UP_LIMIT   = 8'd246;
	localparam logic [7:0]  BRIGHT_DN_LIMIT   = 8'd14;
	localparam logic [7:0]  BRIGHT_MIN        = 8'd5;
	localparam logic [7:0]  HUE_RESET         = 8'd120;
	localparam logic [23:0] COLOR_RESET       = 24'hFF00FF;
	localparam logic [14:0] PERIOD_RESET      = 15'd500;
	localparam logic [14:0] PERIOD_MIN        = 15'd25;
	localparam logic [14:0] PERIOD_DOUBLE_LIM = 15'd20000;
	localparam logic [14:0] PERIOD_MAX        = 15'h7FFF;

	// Decoded remote code
	typedef struct packed {
		logic        power_off;
		logic        bright_up;
		logic        bright_dn;
		logic        pal_hit;
		logic [23:0] pal_rgb;
		logic        rainbow;
		logic        halve;
		logic        period_x2;
	} code_dec_t;

	typedef struct packed {
		src_t        led_source;
		logic [7:0]  hue;
		logic [23:0] color;
		logic [7:0]  brightness;
		mode_t       mode;
		logic        show;
		logic        sleep_request;
		logic [14:0] step_period;
	} result_t;

endpackage

>>> rtl/core/irlc_if.sv
interface irlc_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] ir_code;

	modport source (output valid, output operation, output ir_code, input ready);
	modport sink   (input valid, input operation, input ir_code, output ready);
endinterface

interface irlc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  led_source;
	logic [7:0]  hue_out;
	logic [23:0] color_out;
	logic [7:0]  brightness_out;
	logic        mode_out;
	logic        show;
	logic        sleep_request;
	logic [14:0] step_period;

	modport source (
		output valid, output led_source, output hue_out, output color_out,
		output brightness_out, output mode_out, output show,
		output sleep_request, output step_period, input ready
	);
	modport sink (
		input valid, input led_source, input hue_out, input color_out,
		input brightness_out, input mode_out, input show,
		input sleep_request, input step_period, output ready
	);
endinterface

>>> rtl/core/irlc_decode.sv
module irlc_decode (
	input  logic [31:0]             ir_code,
	output irlc_pkg::code_dec_t     dec
);

	always_comb begin
		dec           = '0;
		dec.power_off = (ir_code == irlc_pkg::CODE_POWER_OFF);
		dec.bright_up = (ir_code == irlc_pkg::CODE_BRIGHT_UP);
		dec.bright_dn = (ir_code == irlc_pkg::CODE_BRIGHT_DN);
		dec.rainbow   = (ir_code == irlc_pkg::CODE_RAINBOW);
		dec.halve     = (ir_code == irlc_pkg::CODE_FASTER_A) ||
		                (ir_code == irlc_pkg::CODE_FASTER_B);
		dec.period_x2 = (ir_code == irlc_pkg::CODE_SLOWER_A) ||
		                (ir_code == irlc_pkg::CODE_SLOWER_B);
		// later entries override earlier ones
		for (int k = 0; k < irlc_pkg::PalDepth; k++) begin
			if (ir_code == irlc_pkg::PAL_CODE_A[k] || ir_code == irlc_pkg::PAL_CODE_B[k]) begin
				dec.pal_hit = 1'b1;
				dec.pal_rgb = irlc_pkg::PAL_RGB[k];
			end
		end
	end

endmodule

>>> rtl/core/irlc_state.sv
module irlc_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  irlc_pkg::op_t        operation,
	input  irlc_pkg::code_dec_t  dec,
	output irlc_pkg::result_t    res
);

	logic [7:0]        bright_q, bright_d;
	irlc_pkg::mode_t   mode_q, mode_d;
	logic [23:0]       color_q, color_d;
	logic [7:0]        hue_q, hue_d;
	logic [14:0]       period_q, period_d;
	logic [14:0]       ticks_q, ticks_d;
	irlc_pkg::src_t    src_q, src_d;
	logic [15:0]       period_dbl;
	logic              show;
	logic              sleep_req;

	assign period_dbl = {period_q, 1'b0};

	always_comb begin
		bright_d  = bright_q;
		mode_d    = mode_q;
		color_d   = color_q;
		hue_d     = hue_q;
		period_d  = period_q;
		ticks_d   = ticks_q;
		src_d     = src_q;
		show      = 1'b0;
		sleep_req = 1'b0;
		if (operation == irlc_pkg::OP_TICK) begin
			if (ticks_q != '0) begin
				ticks_d = ticks_q - 15'd1;
			end else if (mode_q == irlc_pkg::MODE_RAINBOW) begin
				ticks_d = period_q;
				hue_d   = hue_q + 8'd1;
				src_d   = irlc_pkg::SRC_RAINBOW;
				show    = 1'b1;
			end
		end else begin
			if (dec.power_off) begin
				src_d     = irlc_pkg::SRC_BLACK;
				show      = 1'b1;
				sleep_req = 1'b1;
			end
			if (dec.bright_up) begin
				if (bright_q < irlc_pkg::BRIGHT_UP_LIMIT) bright_d = bright_q + irlc_pkg::BRIGHT_STEP;
				show = 1'b1;
			end
			if (dec.bright_dn) begin
				if (bright_q > irlc_pkg::BRIGHT_DN_LIMIT) bright_d = bright_q - irlc_pkg::BRIGHT_STEP;
				show = 1'b1;
			end
			if (dec.pal_hit) begin
				mode_d  = irlc_pkg::MODE_SOLID;
				color_d = dec.pal_rgb;
				src_d   = irlc_pkg::SRC_SOLID;
				show    = 1'b1;
			end
			if (dec.rainbow) mode_d = irlc_pkg::MODE_RAINBOW;
			if (dec.halve) begin
				mode_d = irlc_pkg::MODE_RAINBOW;
				if ((period_q >> 1) < irlc_pkg::PERIOD_MIN) period_d = irlc_pkg::PERIOD_MIN;
				else period_d = period_q >> 1;
			end
			if (dec.period_x2) begin
				mode_d = irlc_pkg::MODE_RAINBOW;
				// the doubled value stays below 40000, so clamp at the 15-bit top
				if (period_q < irlc_pkg::PERIOD_DOUBLE_LIM) begin
					if (period_dbl > {1'b0, irlc_pkg::PERIOD_MAX}) period_d = irlc_pkg::PERIOD_MAX;
					else period_d = period_dbl[14:0];
				end
			end
		end
	end

	always_comb begin
		res.led_source    = src_d;
		res.hue           = hue_d;
		res.color         = color_d;
		res.brightness    = bright_d;
		res.mode          = mode_d;
		res.show          = show;
		res.sleep_request = sleep_req;
		res.step_period   = period_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= irlc_pkg::BRIGHT_RESET;
			mode_q   <= irlc_pkg::MODE_RAINBOW;
			color_q  <= irlc_pkg::COLOR_RESET;
			hue_q    <= irlc_pkg::HUE_RESET;
			period_q <= irlc_pkg::PERIOD_RESET;
			ticks_q  <= '0;
			src_q    <= irlc_pkg::SRC_BLACK;
		end else if (commit) begin
			bright_q <= bright_d;
			mode_q   <= mode_d;
			color_q  <= color_d;
			hue_q    <= hue_d;
			period_q <= period_d;
			ticks_q  <= ticks_d;
			src_q    <= src_d;
		end
	end

endmodule

>>> rtl/core/ir_remote_lamp_controller.sv
// Channel  Dir  Fields
// -------  ---  ---------------------------------------------------------
// item     in   operation (tick / remote code), ir_code[31:0]
// result   out  led_source, hue_out, color_out, brightness_out, mode_out,
//               show, sleep_request, step_period
//
// One transaction in gives one transaction out, through the input and result
// registers when the output side is free. A new item is taken every cycle
// unless a stalled result holds the pipe; the lamp state is updated by the
// code decoder and the state update logic between the two registers.
// Reset clears the lamp state to its power-on values (rainbow, hue 120,
// full brightness, 500 ms step, strip black). A stalled result holds the
// result register and, through it, the input register.
module ir_remote_lamp_controller (
	input  logic        clk,
	input  logic        arst_n,
	irlc_in_if.sink     item,
	irlc_out_if.source  result
);

	// input register
	logic                 valid_s1;
	irlc_pkg::op_t        operation_s1;
	logic [31:0]          ir_code_s1;

	// result register
	logic                 valid_s2;
	irlc_pkg::result_t    result_s2;

	logic                 advance;
	logic                 commit;
	irlc_pkg::code_dec_t  dec;
	irlc_pkg::result_t    res;

	// advance the pipe whenever the result register is empty or being drained
	assign advance    = !valid_s2 || result.ready;
	assign commit     = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			operation_s1 <= irlc_pkg::op_t'(item.operation);
			ir_code_s1   <= item.ir_code;
		end
	end

	irlc_decode u_decode (
		.ir_code (ir_code_s1),
		.dec     (dec)
	);

	// lamp state commits on the same edge that loads the result register
	irlc_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.operation (operation_s1),
		.dec       (dec),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_s2 <= res;
		end
	end

	assign result.valid          = valid_s2;
	assign result.led_source     = result_s2.led_source;
	assign result.hue_out        = result_s2.hue;
	assign result.color_out      = result_s2.color;
	assign result.brightness_out = result_s2.brightness;
	assign result.mode_out       = result_s2.mode;
	assign result.show           = result_s2.show;
	assign result.sleep_request  = result_s2.sleep_request;
	assign result.step_period    = result_s2.step_period;

	// a sleep request always comes with a blanked strip
	a_sleep_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.sleep_request) |-> (result_s2.led_source == irlc_pkg::SRC_BLACK))
		else $error("sleep request without blanked strip");

	// the step period never drops below its floor
	a_period_floor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.step_period >= irlc_pkg::PERIOD_MIN))
		else $error("step period below floor");

	// brightness never falls under the lowest reachable level
	a_bright_floor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.brightness >= irlc_pkg::BRIGHT_MIN))
		else $error("brightness below floor");

	// a committed item always lands in the result register
	a_commit_fills: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> valid_s2)
		else $error("committed item lost");

endmodule

>>> dv/irlc_lamp_checker.sv
module irlc_lamp_checker
	import irlc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	irlc_in_if   item,
	irlc_out_if  result,
	output int   mismatches,
	output int   outstanding,
	output int   compared,
	output int   hue_steps
);

	localparam int MaxPrinted = 30;

	// Palette entry: {first code, second code, color}
	localparam logic [87:0] SWATCH [16] = '{
		{32'h00FF50AF, 32'h2A89195F, 24'h0000FF},
		{32'h00FF10EF, 32'h8C22657B, 24'h00FF00},
		{32'h00FF708F, 32'h44C407DB, 24'hFF55FF},
		{32'h00FF906F, 32'hE5CFBD7F, 24'hFF0000},
		{32'h00FFB04F, 32'hF0C41643, 24'hFF4500},
		{32'h00FFD02F, 32'hD538681B, 24'hFFFFFF},
		{32'h00FF9867, 32'h97483BFB, 24'h999900},
		{32'h00FF18E7, 32'h3D9AE3F7, 24'hADD8E6},
		{32'h00FF30CF, 32'h9716BE3F, 24'h90EE90},
		{32'h00FFA857, 32'hA3C8EDDB, 24'hFFA500},
		{32'h00FF6897, 32'hC101E57B, 24'hFF00FF},
		{32'h00FF8877, 32'h9EF4941F, 24'hFFFF55},
		{32'h00FF08F7, 32'h45473C1B, 24'h5555FF},
		{32'h00FF48B7, 32'hF377C5B7, 24'hEE82EE},
		{32'h00FF58A7, 32'hDC0197DB, 24'hEE82EE},
		{32'h00FF28D7, 32'h13549BDF, 24'h008080}
	};

	logic [7:0]  bright_q;
	mode_t       mode_q;
	logic [23:0] color_q;
	logic [7:0]  hue_q;
	logic [14:0] period_q;
	logic [14:0] countdown_q;
	src_t        src_q;

	result_t     lamp_expected_q [$];
	result_t     want;
	int          errs;
	int          n_compared;
	int          n_steps;

	function automatic result_t advance_lamp(input op_t op, input logic [31:0] code);
		result_t     r;
		logic [15:0] wide;
		r.show = 1'b0;
		r.sleep_request = 1'b0;
		if (op == OP_TICK) begin
			if (countdown_q != 15'd0) begin
				countdown_q = countdown_q - 15'd1;
			end else if (mode_q == MODE_RAINBOW) begin
				countdown_q = period_q;
				hue_q = hue_q + 8'd1;
				src_q = SRC_RAINBOW;
				r.show = 1'b1;
			end
		end else begin
			if (code == CODE_POWER_OFF) begin
				src_q = SRC_BLACK;
				r.show = 1'b1;
				r.sleep_request = 1'b1;
			end
			if (code == CODE_BRIGHT_UP) begin
				if (bright_q < 8'd246)
					bright_q = bright_q + 8'd10;
				r.show = 1'b1;
			end
			if (code == CODE_BRIGHT_DN) begin
				if (bright_q > 8'd14)
					bright_q = bright_q - 8'd10;
				r.show = 1'b1;
			end
			// last matching entry wins
			for (int k = 0; k < 16; k++) begin
				if (code == SWATCH[k][87:56] || code == SWATCH[k][55:24]) begin
					mode_q = MODE_SOLID;
					color_q = SWATCH[k][23:0];
					src_q = SRC_SOLID;
					r.show = 1'b1;
				end
			end
			if (code == CODE_RAINBOW)
				mode_q = MODE_RAINBOW;
			if (code == CODE_FASTER_A || code == CODE_FASTER_B) begin
				mode_q = MODE_RAINBOW;
				period_q = period_q >> 1;
				if (period_q < 15'd25)
					period_q = 15'd25;
			end
			if (code == CODE_SLOWER_A || code == CODE_SLOWER_B) begin
				mode_q = MODE_RAINBOW;
				wide = {1'b0, period_q};
				if (period_q < 15'd20000)
					wide = wide << 1;
				if (wide > 16'd32767)
					wide = 16'd32767;
				period_q = wide[14:0];
			end
		end
		r.led_source = src_q;
		r.hue = hue_q;
		r.color = color_q;
		r.brightness = bright_q;
		r.mode = mode_q;
		r.step_period = period_q;
		return r;
	endfunction

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
		errs++;
		if (errs <= MaxPrinted)
			$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, exp_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q = 8'd255;
			mode_q = MODE_RAINBOW;
			color_q = 24'hFF00FF;
			hue_q = 8'd120;
			period_q = 15'd500;
			countdown_q = 15'd0;
			src_q = SRC_BLACK;
			lamp_expected_q.delete();
			errs = 0;
			n_compared = 0;
			n_steps = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (lamp_expected_q.size() == 0) begin
					report("unrequested transaction", 32'd0, 32'd0);
				end else begin
					want = lamp_expected_q.pop_front();
					n_compared++;
					if (result.led_source !== want.led_source)
						report("led_source", 32'(result.led_source), 32'(want.led_source));
					if (result.hue_out !== want.hue)
						report("hue_out", 32'(result.hue_out), 32'(want.hue));
					if (result.color_out !== want.color)
						report("color_out", 32'(result.color_out), 32'(want.color));
					if (result.brightness_out !== want.brightness)
						report("brightness_out", 32'(result.brightness_out),
							32'(want.brightness));
					if (result.mode_out !== want.mode)
						report("mode_out", 32'(result.mode_out), 32'(want.mode));
					if (result.show !== want.show)
						report("show", 32'(result.show), 32'(want.show));
					if (result.sleep_request !== want.sleep_request)
						report("sleep_request", 32'(result.sleep_request),
							32'(want.sleep_request));
					if (result.step_period !== want.step_period)
						report("step_period", 32'(result.step_period), 32'(want.step_period));
				end
			end
			if (item.valid && item.ready) begin
				want = advance_lamp(op_t'(item.operation), item.ir_code);
				if (want.show && item.operation == OP_TICK)
					n_steps++;
				lamp_expected_q.push_back(want);
			end
		end
		outstanding <= lamp_expected_q.size();
		mismatches <= errs;
		compared <= n_compared;
		hue_steps <= n_steps;
	end

endmodule

>>> dv/ir_remote_lamp_controller_tb.sv
module ir_remote_lamp_controller_tb;
	import irlc_pkg::*;

	localparam int ItemTarget  = 1350;
	localparam int PauseEvery  = 400;
	localparam int StyleEvery  = 150;
	localparam int CycleLimit  = 400000;
	localparam int DrainCycles = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int mismatches;
	int outstanding;
	int compared;
	int hue_steps;

	// Stimulus bookkeeping
	int sent;
	int ticks_sent;
	int send_style;
	int sink_style;
	int cycles;

	irlc_in_if  item_ch ();
	irlc_out_if result_ch ();

	ir_remote_lamp_controller u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Predict every accepted transaction and compare the results in order
	irlc_lamp_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.compared    (compared),
		.hue_steps   (hue_steps)
	);

	always #10 clk = ~clk;

	// Draw a per-transaction wait: style 0 runs back to back, style 1 draws
	// a random wait every time, style 2 stalls only now and then.
	function automatic int draw_wait(input int style);
		case (style)
			0: begin
				return 0;
			end
			1: begin
				return $urandom_range(0, 14);
			end
			default: begin
				return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
			end
		endcase
	endfunction

	// Pick any code the lamp knows: action codes and both palette columns
	function automatic logic [31:0] any_known_code();
		int k;
		k = $urandom_range(0, 2 * PalDepth + 7);
		if (k < PalDepth)
			return PAL_CODE_A[k];
		if (k < 2 * PalDepth)
			return PAL_CODE_B[k - PalDepth];
		case (k - 2 * PalDepth)
			0: return CODE_POWER_OFF;
			1: return CODE_BRIGHT_UP;
			2: return CODE_BRIGHT_DN;
			3: return CODE_RAINBOW;
			4: return CODE_FASTER_A;
			5: return CODE_FASTER_B;
			6: return CODE_SLOWER_A;
			default: return CODE_SLOWER_B;
		endcase
	endfunction

	// Offer one transaction after a random gap and hold it until accepted.
	// Valid stays high across back-to-back transactions.
	task automatic send(input op_t op, input logic [31:0] code);
		int gap;
		gap = draw_wait(send_style);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.operation <= op;
		item_ch.ir_code <= code;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
		if (op == OP_TICK)
			ticks_sent++;
		if (sent % StyleEvery == 0)
			send_style = $urandom_range(0, 2);
	endtask

	// Drop valid and hold off until every predicted result has come back
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// One random burst. Runs of the same code push brightness and period to
	// their limits; tick runs let the countdown expire at short periods.
	task automatic random_burst();
		int          kind;
		int          n;
		int          k;
		logic [31:0] code;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			n = $urandom_range(1, 60);
			repeat (n) send(OP_TICK, $urandom());
		end else if (kind < 42) begin
			code = $urandom_range(0, 1) ? CODE_BRIGHT_UP : CODE_BRIGHT_DN;
			n = $urandom_range(1, 28);
			repeat (n) send(OP_CODE, code);
		end else if (kind < 52) begin
			n = $urandom_range(1, 10);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0: code = CODE_FASTER_A;
					1: code = CODE_FASTER_B;
					2: code = CODE_SLOWER_A;
					default: code = CODE_SLOWER_B;
				endcase
				send(OP_CODE, code);
			end
		end else if (kind < 66) begin
			k = $urandom_range(0, PalDepth - 1);
			send(OP_CODE, $urandom_range(0, 1) ? PAL_CODE_A[k] : PAL_CODE_B[k]);
		end else if (kind < 74) begin
			send(OP_CODE, $urandom_range(0, 1) ? CODE_RAINBOW : CODE_POWER_OFF);
		end else if (kind < 84) begin
			send(OP_CODE, $urandom());
		end else if (kind < 90) begin
			// same vendor prefix as the real codes, random command byte pair
			code = $urandom();
			send(OP_CODE, {16'h00FF, code[15:0]});
		end else begin
			// near miss: a known code with one bit flipped
			send(OP_CODE, any_known_code() ^ (32'd1 << $urandom_range(0, 31)));
		end
	endtask

	// Receiver: stall a random number of cycles per result, then hold ready
	// until the result transaction goes through.
	initial begin
		int stall;
		int taken;
		result_ch.ready <= 1'b0;
		taken = 0;
		sink_style = 1;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken % StyleEvery == 0)
				sink_style = $urandom_range(0, 2);
			stall = draw_wait(sink_style);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			taken++;
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("ir_remote_lamp_controller verification failed");
			$finish;
		end
	end

	initial begin
		int next_pause;
		sent = 0;
		ticks_sent = 0;
		send_style = 1;
		item_ch.valid <= 1'b0;
		item_ch.operation <= OP_TICK;
		item_ch.ir_code <= 32'd0;

		// Hold reset low, then release it once
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The timer starts expired, so the first tick steps
		// the hue; the second only counts down.
		send(OP_TICK, 32'd0);
		send(OP_TICK, 32'hFFFF_FFFF);
		// Brightness is already at the ceiling: up holds, down lowers
		send(OP_CODE, CODE_BRIGHT_UP);
		send(OP_CODE, CODE_BRIGHT_DN);
		send(OP_CODE, CODE_POWER_OFF);
		// Solid colors from both ends of the palette, both code columns
		send(OP_CODE, PAL_CODE_A[0]);
		// Countdown keeps running in solid mode
		send(OP_TICK, 32'h5A5A_A5A5);
		send(OP_CODE, PAL_CODE_B[PalDepth - 1]);
		send(OP_CODE, PAL_CODE_A[13]);
		send(OP_CODE, PAL_CODE_B[14]);
		send(OP_CODE, CODE_RAINBOW);
		// Period halving and doubling through both codes of each
		send(OP_CODE, CODE_FASTER_A);
		send(OP_CODE, CODE_FASTER_B);
		send(OP_CODE, CODE_SLOWER_A);
		send(OP_CODE, CODE_SLOWER_B);
		// Unknown codes change nothing
		send(OP_CODE, 32'h0000_0000);
		send(OP_CODE, 32'hFFFF_FFFF);
		send(OP_CODE, 32'h00FF_0000);
		// Leave solid mode through a period change
		send(OP_CODE, PAL_CODE_B[7]);
		send(OP_CODE, CODE_SLOWER_A);
		send(OP_CODE, CODE_POWER_OFF);
		send(OP_TICK, 32'h0000_0001);

		// Hold off until the pipeline has drained at least once
		wait_idle();

		// Random part
		next_pause = sent + PauseEvery;
		while (sent < ItemTarget) begin
			random_burst();
			if (sent >= next_pause) begin
				wait_idle();
				next_pause = sent + PauseEvery;
			end
		end

		// Drain: wait for every result, then let the pipeline idle
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DrainCycles) @(posedge clk);

		$display("sent %0d transactions: %0d ticks, %0d remote codes; %0d results compared",
			sent, ticks_sent, sent - ticks_sent, compared);
		$display("rainbow hue advanced %0d times; %0d mismatches", hue_steps, mismatches);
		if (mismatches == 0) begin
			$display("ir_remote_lamp_controller verification clean");
		end else begin
			$display("ir_remote_lamp_controller verification failed");
		end
		$finish;
	end

endmodule
